// ----- rtl/mbr_pkg.sv -----
// Shared types and constants for the MSB-first bit reader.
// Used by mbr_front, mbr_back and msb_first_bit_reader_core; no dependencies.
package mbr_pkg;

  // Word and field widths
  localparam int WORD_BITS = 32;
  localparam int WIDE_BITS = 2 * WORD_BITS;
  localparam int COUNT_W   = 6;
  localparam int CMD_W     = 3;
  localparam int BYTE_BITS = 8;

  localparam logic [COUNT_W-1:0] WORD_CNT = COUNT_W'(WORD_BITS);

  // Queue geometry between and behind the two halves
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the cmd port
  localparam logic [CMD_W-1:0] CMD_GET        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN_BYTE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ALIGN_WORD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REWIND     = 3'd4;

  // Operation kinds after classification
  localparam logic [2:0] OP_GET        = 3'd0;
  localparam logic [2:0] OP_APPEND     = 3'd1;
  localparam logic [2:0] OP_ALIGN_BYTE = 3'd2;
  localparam logic [2:0] OP_ALIGN_WORD = 3'd3;
  localparam logic [2:0] OP_REWIND     = 3'd4;
  localparam logic [2:0] OP_NOP        = 3'd5;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [2:0]           kind;
    logic [COUNT_W-1:0]   count;
    logic [WORD_BITS-1:0] prior;
    logic [WORD_BITS-1:0] word;
    logic                 word_ok;
  } op_t;

  // One result beat
  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic                 taken;
    logic [COUNT_W-1:0]   left;
    logic                 aligned;
    logic                 failed;
  } res_t;

endpackage

// ----- rtl/mbr_front.sv -----
// Front end of the bit reader: accepts input beats, decodes the command,
// saturates the bit count and queues the classified operation. Uses mbr_pkg.
module mbr_front import mbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [COUNT_W-1:0]   bit_count,
  input  logic [WORD_BITS-1:0] prior_bits,
  input  logic [WORD_BITS-1:0] next_word,
  input  logic                 next_word_ok,
  output logic                 op_valid,
  input  logic                 op_take,
  output op_t                  op
);

  op_t               op_in;
  op_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  // Classify the command and clamp the count
  always_comb begin
    op_in.prior   = prior_bits;
    op_in.word    = next_word;
    op_in.word_ok = next_word_ok;
    op_in.count   = (bit_count > WORD_CNT) ? WORD_CNT : bit_count;
    unique case (cmd)
      CMD_GET:        op_in.kind = OP_GET;
      CMD_APPEND:     op_in.kind = OP_APPEND;
      CMD_ALIGN_BYTE: op_in.kind = OP_ALIGN_BYTE;
      CMD_ALIGN_WORD: op_in.kind = OP_ALIGN_WORD;
      CMD_REWIND:     op_in.kind = OP_REWIND;
      default:        op_in.kind = OP_NOP;
    endcase
  end

  assign full     = (fill == FILL_W'(QUEUE_DEPTH));
  assign op_valid = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = op_take && op_valid;
  assign op       = slots[rd_ptr];

  // Operation queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mbr_back.sv -----
// Back end of the bit reader: holds the bit buffer, executes one queued
// operation per cycle while the result queue has room and queues the result beat. Uses mbr_pkg.
module mbr_back import mbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_take,
  input  op_t                  op,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res
);

  logic [WORD_BITS-1:0] bit_buffer;
  logic [COUNT_W-1:0]   held_count;
  logic                 failed_flag;
  logic [WORD_BITS-1:0] bit_buffer_next;
  logic [COUNT_W-1:0]   held_count_next;
  logic                 failed_flag_next;

  logic [COUNT_W-1:0]   take;
  logic [COUNT_W-1:0]   low;
  logic [WIDE_BITS-1:0] buf_wide;
  logic [WIDE_BITS-1:0] word_wide;
  logic [WORD_BITS-1:0] prior_shl;
  logic [WORD_BITS-1:0] fresh;
  logic                 taken;
  res_t                 res_in;

  res_t                 slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [FILL_W-1:0]    fill;
  logic                 res_full;
  logic                 do_pop;

  assign res_full = (fill == FILL_W'(QUEUE_DEPTH));
  assign op_take  = op_valid && !res_full;

  // Number of bits this operation consumes from the buffer
  always_comb begin
    unique case (op.kind)
      OP_GET, OP_APPEND: take = op.count;
      OP_ALIGN_BYTE:     take = COUNT_W'(held_count % BYTE_BITS);
      OP_ALIGN_WORD:     take = (held_count != '0 && held_count != WORD_CNT) ?
                                held_count : '0;
      default:           take = '0;
    endcase
  end

  // Shifters: upper half of a wide shift gives the top bits right-aligned
  assign low       = take - held_count;
  assign buf_wide  = {{WORD_BITS{1'b0}}, bit_buffer} << take;
  assign word_wide = {{WORD_BITS{1'b0}}, op.word} << low;
  assign prior_shl = op.prior << take;

  // Take bits, refilling from the supplied word when the buffer runs short
  always_comb begin
    fresh            = '0;
    taken            = 1'b0;
    bit_buffer_next  = bit_buffer;
    held_count_next  = held_count;
    failed_flag_next = failed_flag;
    if (take <= held_count) begin
      fresh           = buf_wide[WIDE_BITS-1:WORD_BITS];
      bit_buffer_next = buf_wide[WORD_BITS-1:0];
      held_count_next = held_count - take;
    end else if (op.word_ok) begin
      fresh           = buf_wide[WIDE_BITS-1:WORD_BITS] | word_wide[WIDE_BITS-1:WORD_BITS];
      taken           = 1'b1;
      bit_buffer_next = word_wide[WORD_BITS-1:0];
      held_count_next = WORD_CNT - low;
    end else begin
      bit_buffer_next  = '0;
      held_count_next  = '0;
      failed_flag_next = 1'b1;
    end
    // Rewind clears everything
    if (op.kind == OP_REWIND) begin
      bit_buffer_next  = '0;
      held_count_next  = '0;
      failed_flag_next = 1'b0;
    end
  end

  // Assemble the result beat
  always_comb begin
    unique case (op.kind)
      OP_GET:    res_in.bits = fresh;
      OP_APPEND: res_in.bits = prior_shl | fresh;
      default:   res_in.bits = '0;
    endcase
    res_in.taken   = taken;
    res_in.left    = held_count_next;
    res_in.aligned = (held_count_next == '0) || (held_count_next == WORD_CNT);
    res_in.failed  = failed_flag_next;
  end

  // Reader state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer  <= '0;
      held_count  <= '0;
      failed_flag <= 1'b0;
    end else if (op_take) begin
      bit_buffer  <= bit_buffer_next;
      held_count  <= held_count_next;
      failed_flag <= failed_flag_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (op_take) begin
      slots[wr_ptr] <= res_in;
    end
  end

  assign empty  = (fill == '0);
  assign do_pop = pop && !empty;
  assign res    = slots[rd_ptr];

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (op_take) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (op_take && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !op_take) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/msb_first_bit_reader_core.sv -----
// MSB-first bit reader over a big-endian 32-bit word stream. Each input beat
// carries one command (get, append, align byte, align word, rewind) and gives
// exactly one result beat. The block sustains one beat per clock while the
// result queue is not full: a beat is held in the front queue and executed by
// the back end, whose buffer update (a 64-bit shift plus the one-step refill
// from next_word) sets that rate; a result is registered in the result queue,
// behind the front queue, before it reaches the output ports.
// Two-entry queues on each side let input and output stall
// independently. Depends on mbr_pkg, mbr_front and mbr_back.
module msb_first_bit_reader_core import mbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [COUNT_W-1:0]   bit_count,
  input  logic [WORD_BITS-1:0] prior_bits,
  input  logic [WORD_BITS-1:0] next_word,
  input  logic                 next_word_ok,
  output logic                 empty,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] bits_out,
  output logic                 word_taken,
  output logic [COUNT_W-1:0]   bits_left,
  output logic                 segment_aligned,
  output logic                 read_failed
);

  logic op_valid;
  logic op_take;
  op_t  op;
  res_t res;

  mbr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .bit_count    (bit_count),
    .prior_bits   (prior_bits),
    .next_word    (next_word),
    .next_word_ok (next_word_ok),
    .op_valid     (op_valid),
    .op_take      (op_take),
    .op           (op)
  );

  mbr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_take  (op_take),
    .op       (op),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign bits_out        = res.bits;
  assign word_taken      = res.taken;
  assign bits_left       = res.left;
  assign segment_aligned = res.aligned;
  assign read_failed     = res.failed;

endmodule
